/* sv/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned FIELD_W = 21;
  localparam int unsigned NEED_W  = FIELD_W + 1;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [FIELD_W-1:0] HEAP_RESET = 21'h100000;

  // Request actions.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  // Register byte addresses.
  localparam logic [PADDR_W-1:0] REG_HEAP_SIZE = 2'd0;

  // Table write sources.
  localparam logic [2:0] W_INIT     = 3'd0;
  localparam logic [2:0] W_TAKEN    = 3'd1;
  localparam logic [2:0] W_FREED    = 3'd2;
  localparam logic [2:0] W_COPY     = 3'd3;
  localparam logic [2:0] W_SPLIT_LO = 3'd4;
  localparam logic [2:0] W_SPLIT_HI = 3'd5;
  localparam logic [2:0] W_FOLD     = 3'd6;

  typedef struct packed {
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] bytes;
    logic               taken;
  } entry_t;

  typedef struct packed {
    logic       we;
    logic [2:0] wsel;
    logic       ld_req;
    logic       ld_hold;
    logic       ld_out;
    logic       grant;
    logic       count_one;
  } dp_cmd_t;

  typedef struct packed {
    logic fit;
    logic match;
    logic taken;
    logic big_left;
    logic all_free;
  } dp_stat_t;

endpackage

/* sv/ffha_req_if.sv */
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel: one allocate or free item per handshake.
// ----------------------------------------------------------------------------
interface ffha_req_if
  import ffha_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               action;
  logic [FIELD_W-1:0] request_size;
  logic [FIELD_W-1:0] address;

  modport source (output valid, action, request_size, address, input ready);
  modport sink   (input valid, action, request_size, address, output ready);
endinterface

/* sv/ffha_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Result channel: status, granted offset and all-free flag per item.
// ----------------------------------------------------------------------------
interface ffha_rsp_if
  import ffha_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FIELD_W-1:0] granted_offset;
  logic               all_free;

  modport source (output valid, status, granted_offset, all_free, input ready);
  modport sink   (input valid, status, granted_offset, all_free, output ready);
endinterface

/* sv/first_fit_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator with coalescing over an address-ordered table.
// ----------------------------------------------------------------------------
// Requests arrive on req_i: an allocate of request_size bytes or a free of
// the chunk whose usable start is address. Each request yields one item on
// rsp_o with status, granted offset and the all-free flag.
// One request is worked on at a time. The chunk table sits in a single-port
// read, single-port write memory, so table accesses go one at a time: the
// scan reads and then checks each entry visited, a split shifts the table
// tail one entry at a time, and each merge closes the gap one entry at a time.
// A new request is taken while the previous result still waits on rsp_o;
// a stalled result stops the block only when the next result is ready.
// After reset, and after each write of heap_size over the APB port, the
// table is rebuilt as one free chunk before any request is accepted.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS   = 64,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned ALIGN_BYTES  = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ffha_req_if.sink           req_i,
  ffha_rsp_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned IW = $clog2(MAX_CHUNKS);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [IW-1:0]      raddr;
  logic [IW-1:0]      waddr;
  logic [1:0]         res_status;
  logic [FIELD_W-1:0] heap_size;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr == REG_HEAP_SIZE);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_HEAP_SIZE) ? PDATA_W'(heap_size) : '0;

  ffha_ctrl #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_wr),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_action_i (req_i.action),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .res_status_o (res_status),
    .raddr_o      (raddr),
    .waddr_o      (waddr)
  );

  ffha_dp #(
    .MAX_CHUNKS   (MAX_CHUNKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_wr),
    .cfg_data_i   (pwdata[FIELD_W-1:0]),
    .heap_size_o  (heap_size),
    .req_size_i   (req_i.request_size),
    .req_addr_i   (req_i.address),
    .res_status_i (res_status),
    .cmd_i        (cmd),
    .raddr_i      (raddr),
    .waddr_i      (waddr),
    .stat_o       (stat),
    .status_o     (rsp_o.status),
    .offset_o     (rsp_o.granted_offset),
    .all_free_o   (rsp_o.all_free)
  );

endmodule

/* sv/ffha_dp.sv */
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: chunk table memory, held entry, request and result registers.
// ----------------------------------------------------------------------------
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS   = 64,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned ALIGN_BYTES  = 4,
  localparam int unsigned IW = $clog2(MAX_CHUNKS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_i,
  input  logic [FIELD_W-1:0] cfg_data_i,
  output logic [FIELD_W-1:0] heap_size_o,
  input  logic [FIELD_W-1:0] req_size_i,
  input  logic [FIELD_W-1:0] req_addr_i,
  input  logic [1:0]         res_status_i,
  input  dp_cmd_t            cmd_i,
  input  logic [IW-1:0]      raddr_i,
  input  logic [IW-1:0]      waddr_i,
  output dp_stat_t           stat_o,
  output logic [1:0]         status_o,
  output logic [FIELD_W-1:0] offset_o,
  output logic               all_free_o
);

  localparam logic [FIELD_W+1:0] HDR = (FIELD_W+2)'(HEADER_BYTES);

  entry_t             mem_q [MAX_CHUNKS];
  entry_t             rdata_q;
  entry_t             hold_q;
  entry_t             wdata;
  logic [FIELD_W-1:0] heap_q;
  logic [NEED_W-1:0]  need_q, need_d;
  logic [NEED_W-1:0]  round_sum;
  logic [FIELD_W-1:0] addr_q;
  logic [FIELD_W-1:0] left;
  logic [FIELD_W+1:0] fold_sum;
  logic [FIELD_W+1:0] hi_start;
  logic [1:0]         status_q;
  logic [FIELD_W-1:0] offset_q;
  logic               all_free_q;

  assign round_sum = {1'b0, req_size_i} + NEED_W'(ALIGN_BYTES - 1);
  assign need_d    = NEED_W'((round_sum / ALIGN_BYTES) * ALIGN_BYTES);

  // Leftover is only used after a fit, where need is below the chunk size.
  assign left     = hold_q.bytes - need_q[FIELD_W-1:0];
  assign fold_sum = {2'b00, hold_q.bytes} + HDR + {2'b00, rdata_q.bytes};
  assign hi_start = {2'b00, hold_q.start} + {1'b0, need_q} + HDR;

  always_comb begin
    wdata = hold_q;
    case (cmd_i.wsel)
      W_INIT: begin
        wdata.start = FIELD_W'(HEADER_BYTES);
        wdata.bytes = ({2'b00, heap_q} > HDR) ? FIELD_W'({2'b00, heap_q} - HDR) : '0;
        wdata.taken = 1'b0;
      end
      W_TAKEN: wdata.taken = 1'b1;
      W_FREED: wdata.taken = 1'b0;
      W_COPY:  wdata = rdata_q;
      W_SPLIT_LO: begin
        wdata.bytes = need_q[FIELD_W-1:0];
        wdata.taken = 1'b1;
      end
      W_SPLIT_HI: begin
        wdata.start = hi_start[FIELD_W-1:0];
        wdata.bytes = FIELD_W'({2'b00, left} - HDR);
        wdata.taken = 1'b0;
      end
      W_FOLD:  wdata.bytes = fold_sum[FIELD_W-1:0];
      default: wdata = hold_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      need_q <= need_d;
      addr_q <= req_addr_i;
    end
    if (cmd_i.ld_hold) begin
      hold_q <= rdata_q;
    end
    if (cmd_i.ld_out) begin
      status_q   <= res_status_i;
      offset_q   <= cmd_i.grant ? hold_q.start : '0;
      all_free_q <= cmd_i.count_one & stat_o.all_free;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= HEAP_RESET;
    end else if (cfg_wr_i) begin
      heap_q <= cfg_data_i;
    end
  end

  assign stat_o.fit      = !rdata_q.taken && (need_q < {1'b0, rdata_q.bytes});
  assign stat_o.match    = (rdata_q.start == addr_q);
  assign stat_o.taken    = rdata_q.taken;
  assign stat_o.big_left = ({2'b00, left} > HDR);
  assign stat_o.all_free = !rdata_q.taken &&
                           (({2'b00, rdata_q.bytes} + HDR) == {2'b00, heap_q});

  assign heap_size_o = heap_q;
  assign status_o    = status_q;
  assign offset_o    = offset_q;
  assign all_free_o  = all_free_q;

endmodule

/* sv/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences table scans, splits, shifts and merges.
// ----------------------------------------------------------------------------
module ffha_ctrl
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS = 64,
  localparam int unsigned IW = $clog2(MAX_CHUNKS),
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_i,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic          req_action_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  dp_stat_t      stat_i,
  output dp_cmd_t       cmd_o,
  output logic [1:0]    res_status_o,
  output logic [IW-1:0] raddr_o,
  output logic [IW-1:0] waddr_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_SC_RD  = 5'd2;
  localparam logic [4:0] S_SC_CK  = 5'd3;
  localparam logic [4:0] S_AL_DEC = 5'd4;
  localparam logic [4:0] S_SH_RD  = 5'd5;
  localparam logic [4:0] S_SH_WR  = 5'd6;
  localparam logic [4:0] S_AL_LO  = 5'd7;
  localparam logic [4:0] S_AL_HI  = 5'd8;
  localparam logic [4:0] S_FR_CLR = 5'd9;
  localparam logic [4:0] S_FR_N1  = 5'd10;
  localparam logic [4:0] S_FR_N1C = 5'd11;
  localparam logic [4:0] S_FR_N2C = 5'd12;
  localparam logic [4:0] S_FD_RD0 = 5'd13;
  localparam logic [4:0] S_FD_RD1 = 5'd14;
  localparam logic [4:0] S_FD_WR  = 5'd15;
  localparam logic [4:0] S_FS_RD  = 5'd16;
  localparam logic [4:0] S_FS_WR  = 5'd17;
  localparam logic [4:0] S_FR_P   = 5'd18;
  localparam logic [4:0] S_FR_PC  = 5'd19;
  localparam logic [4:0] S_FIN_RD = 5'd20;
  localparam logic [4:0] S_FIN    = 5'd21;

  // Where a merge returns to.
  localparam logic [1:0] RET_FOLD_I = 2'd0;
  localparam logic [1:0] RET_PREV   = 2'd1;
  localparam logic [1:0] RET_DONE   = 2'd2;

  localparam logic [CW:0] MAX_E = (CW+1)'(MAX_CHUNKS);

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] i_q, i_d, k_q, k_d, a_q, a_d, cnt_q, cnt_d;
  logic          act_q, act_d;
  logic [1:0]    res_q, res_d;
  logic [1:0]    fret_q, fret_d;
  logic          pend_q, pend_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic [CW:0]   i_e, k_e, cnt_e, i1_e, i2_e, k1_e;
  logic [CW-1:0] i1, i2, im1, k1, km1, a1;

  assign i_e   = {1'b0, i_q};
  assign k_e   = {1'b0, k_q};
  assign cnt_e = {1'b0, cnt_q};
  assign i1_e  = i_e + 1'b1;
  assign i2_e  = i_e + 2'd2;
  assign k1_e  = k_e + 1'b1;
  assign i1    = i_q + 1'b1;
  assign i2    = i_q + 2'd2;
  assign im1   = i_q - 1'b1;
  assign k1    = k_q + 1'b1;
  assign km1   = k_q - 1'b1;
  assign a1    = a_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    k_d         = k_q;
    a_d         = a_q;
    cnt_d       = cnt_q;
    act_d       = act_q;
    res_d       = res_q;
    fret_d      = fret_q;
    pend_d      = pend_q;
    rsp_valid_d = rsp_valid_q;
    cmd_o       = '0;
    cmd_o.wsel  = W_COPY;
    raddr_o     = '0;
    waddr_o     = i_q[IW-1:0];
    req_ready_o = (state_q == S_IDLE) && !pend_q;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (pend_q) begin
          state_d = S_INIT;
        end else if (req_valid_i) begin
          cmd_o.ld_req = 1'b1;
          act_d        = req_action_i;
          res_d        = ST_OK;
          i_d          = '0;
          state_d      = S_SC_RD;
        end
      end
      S_INIT: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = W_INIT;
        waddr_o    = '0;
        cnt_d      = CW'(1);
        pend_d     = 1'b0;
        state_d    = S_IDLE;
      end
      S_SC_RD: begin
        if (i_e >= cnt_e) begin
          res_d   = (act_q == ACT_FREE) ? ST_BADADDR : ST_NOFIT;
          state_d = S_FIN_RD;
        end else begin
          raddr_o = i_q[IW-1:0];
          state_d = S_SC_CK;
        end
      end
      S_SC_CK: begin
        if ((act_q == ACT_FREE) ? stat_i.match : stat_i.fit) begin
          cmd_o.ld_hold = 1'b1;
          state_d       = (act_q == ACT_FREE) ? S_FR_CLR : S_AL_DEC;
        end else begin
          i_d     = i1;
          state_d = S_SC_RD;
        end
      end
      S_AL_DEC: begin
        if (stat_i.big_left && (cnt_e < MAX_E)) begin
          k_d     = cnt_q;
          state_d = S_SH_RD;
        end else begin
          cmd_o.we   = 1'b1;
          cmd_o.wsel = W_TAKEN;
          state_d    = S_FIN_RD;
        end
      end
      S_SH_RD: begin
        if (k_e > i1_e) begin
          raddr_o = km1[IW-1:0];
          state_d = S_SH_WR;
        end else begin
          state_d = S_AL_LO;
        end
      end
      S_SH_WR: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = W_COPY;
        waddr_o    = k_q[IW-1:0];
        k_d        = km1;
        state_d    = S_SH_RD;
      end
      S_AL_LO: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = W_SPLIT_LO;
        state_d    = S_AL_HI;
      end
      S_AL_HI: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = W_SPLIT_HI;
        waddr_o    = i1[IW-1:0];
        cnt_d      = cnt_q + 1'b1;
        state_d    = S_FIN_RD;
      end
      S_FR_CLR: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = W_FREED;
        state_d    = S_FR_N1;
      end
      S_FR_N1: begin
        if (i1_e < cnt_e) begin
          raddr_o = i1[IW-1:0];
          state_d = S_FR_N1C;
        end else begin
          state_d = S_FR_P;
        end
      end
      S_FR_N1C: begin
        if (stat_i.taken) begin
          state_d = S_FR_P;
        end else if (i2_e < cnt_e) begin
          raddr_o = i2[IW-1:0];
          state_d = S_FR_N2C;
        end else begin
          a_d     = i_q;
          fret_d  = RET_PREV;
          state_d = S_FD_RD0;
        end
      end
      S_FR_N2C: begin
        // With both followers free, the far pair merges first.
        if (!stat_i.taken) begin
          a_d    = i1;
          fret_d = RET_FOLD_I;
        end else begin
          a_d    = i_q;
          fret_d = RET_PREV;
        end
        state_d = S_FD_RD0;
      end
      S_FD_RD0: begin
        raddr_o = a_q[IW-1:0];
        state_d = S_FD_RD1;
      end
      S_FD_RD1: begin
        cmd_o.ld_hold = 1'b1;
        raddr_o       = a1[IW-1:0];
        state_d       = S_FD_WR;
      end
      S_FD_WR: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = W_FOLD;
        waddr_o    = a_q[IW-1:0];
        k_d        = a1;
        state_d    = S_FS_RD;
      end
      S_FS_RD: begin
        if (k1_e < cnt_e) begin
          raddr_o = k1[IW-1:0];
          state_d = S_FS_WR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          case (fret_q)
            RET_FOLD_I: begin
              a_d     = i_q;
              fret_d  = RET_PREV;
              state_d = S_FD_RD0;
            end
            RET_PREV: state_d = S_FR_P;
            default:  state_d = S_FIN_RD;
          endcase
        end
      end
      S_FS_WR: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = W_COPY;
        waddr_o    = k_q[IW-1:0];
        k_d        = k1;
        state_d    = S_FS_RD;
      end
      S_FR_P: begin
        if (i_q != '0) begin
          raddr_o = im1[IW-1:0];
          state_d = S_FR_PC;
        end else begin
          state_d = S_FIN_RD;
        end
      end
      S_FR_PC: begin
        if (!stat_i.taken) begin
          a_d     = im1;
          fret_d  = RET_DONE;
          state_d = S_FD_RD0;
        end else begin
          state_d = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        // Entry 0 is on the read port here for the all-free check.
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.ld_out    = 1'b1;
          cmd_o.grant     = (act_q == ACT_ALLOC) && (res_q == ST_OK);
          cmd_o.count_one = (cnt_q == CW'(1));
          rsp_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_wr_i) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      k_q         <= '0;
      a_q         <= '0;
      cnt_q       <= CW'(1);
      act_q       <= ACT_ALLOC;
      res_q       <= ST_OK;
      fret_q      <= RET_DONE;
      pend_q      <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      k_q         <= k_d;
      a_q         <= a_d;
      cnt_q       <= cnt_d;
      act_q       <= act_d;
      res_q       <= res_d;
      fret_q      <= fret_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign res_status_o = res_q;

endmodule
